// ===== hdl/cotr_pkg.sv =====
// Shared types, widths and the root profile generator for the circle rasterizer.
`timescale 1ns / 1ps
`default_nettype none

package cotr_pkg;

  localparam int unsigned XW         = 9;
  localparam int unsigned YW         = 8;
  localparam int unsigned RadiusW    = 7;
  localparam int unsigned ColorW     = 8;
  localparam int unsigned AddrW      = 16;
  localparam int unsigned AccW       = 18;
  localparam int unsigned RecipW     = 17;
  localparam int unsigned RootW      = 17;
  localparam int unsigned OctW       = 3;
  localparam int unsigned FracW      = 16;

  localparam int unsigned DefTableDepth = 1024;
  localparam int unsigned DefLineStride = 320;

  // Dividend of the reciprocal: 1.0 in 16.16.
  localparam logic [RecipW-1:0] RecipNum = RecipW'(32'h1_0000);
  localparam logic [OctW-1:0]   LastOct  = OctW'(7);

  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_FETCH,
    ST_SCALE,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic               start;
    logic [RadiusW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [RecipW-1:0] quotient;
  } div_rsp_t;

  // Entry idx of the root profile: the largest r with r*r*depth^2 <= 2^32*(depth^2-idx^2),
  // which is floor(65536*sqrt(1-(idx/depth)^2)). Only evaluated on constants.
  function automatic logic [RootW-1:0] root_entry(int unsigned idx, int unsigned depth);
    longint unsigned d2;
    longint unsigned lim;
    longint unsigned r;
    longint unsigned t;
    d2  = longint'(depth) * longint'(depth);
    lim = (64'd1 << 32) * (d2 - longint'(idx) * longint'(idx));
    r   = 0;
    for (int b = RootW - 1; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t * d2 <= lim) begin
        r = t;
      end
    end
    return r[RootW-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== hdl/cotr_if.sv =====
// Valid/ready channel interfaces for the input and output words of the rasterizer.
`timescale 1ns / 1ps
`default_nettype none

interface cotr_in_if
  import cotr_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               opcode;
  logic [XW-1:0]      center_x;
  logic [YW-1:0]      center_y;
  logic [RadiusW-1:0] radius;
  logic [ColorW-1:0]  color;

  modport source (output valid, opcode, center_x, center_y, radius, color, input ready);
  modport sink   (input valid, opcode, center_x, center_y, radius, color, output ready);
endinterface

interface cotr_out_if
  import cotr_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [AddrW-1:0]  pixel_address;
  logic [ColorW-1:0] pixel_color;
  logic              last;
  logic              done_res;

  modport source (output valid, pixel_address, pixel_color, last, done_res, input ready);
  modport sink   (input valid, pixel_address, pixel_color, last, done_res, output ready);
endinterface

`default_nettype wire

// ===== hdl/cotr_div.sv =====
// Restoring divider, one quotient bit per cycle, for the reciprocal 65536/radius.
`timescale 1ns / 1ps
`default_nettype none

module cotr_div
  import cotr_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output div_rsp_t      rsp_o
);

  localparam int unsigned CntW = $clog2(RecipW + 1);

  logic                busy_q;
  logic                done_q;
  logic [CntW-1:0]     cnt_q;
  logic [RadiusW-1:0]  rem_q;
  logic [RadiusW-1:0]  dvs_q;
  logic [RecipW-1:0]   quo_q;

  logic [RadiusW:0]    shifted;
  logic [RadiusW+1:0]  trial;
  logic                qbit;

  // Shift in the next dividend bit and try to subtract the divisor.
  assign shifted = {rem_q, quo_q[RecipW-1]};
  assign trial   = {1'b0, shifted} - {2'b00, dvs_q};
  assign qbit    = ~trial[RadiusW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CntW'(1));
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(RecipW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      dvs_q <= req_i.divisor;
      quo_q <= RecipNum;
    end else if (busy_q) begin
      rem_q <= qbit ? trial[RadiusW-1:0] : shifted[RadiusW-1:0];
      quo_q <= {quo_q[RecipW-2:0], qbit};
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

`default_nettype wire

// ===== hdl/cotr_rom.sv =====
// Root profile ROM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module cotr_rom
  import cotr_pkg::*;
#(
  parameter int unsigned TableDepth = DefTableDepth
) (
  input  wire logic                          clk_i,
  input  wire logic [$clog2(TableDepth)-1:0] addr_i,
  output logic      [RootW-1:0]              data_o
);

  logic [RootW-1:0] rom_mem [TableDepth];
  logic [RootW-1:0] data_q;

  for (genvar gi = 0; gi < TableDepth; gi++) begin : g_entry
    assign rom_mem[gi] = root_entry(gi, TableDepth);
  end

  always_ff @(posedge clk_i) begin
    data_q <= rom_mem[addr_i];
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

// ===== hdl/circle_outline_table_rasterizer.sv =====
// Circle outline rasterizer: sequencer, octant address generator and output register.
// Start: after acceptance the sequencer waits on the reciprocal divider (17 quotient bits).
// Step: the root table read and the radius scaling, then eight pixel words,
// one per cycle while the sink is ready; no new word is taken until the eighth is issued.
// Reset is asynchronous and active low; it clears the sequencer, the active flag and the
// output valid. The root table is a constant ROM and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module circle_outline_table_rasterizer
  import cotr_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = DefTableDepth,
  parameter int unsigned LINE_STRIDE = DefLineStride
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  cotr_in_if.sink     in_i,
  cotr_out_if.source  out_o
);

  localparam int unsigned IdxW   = $clog2(TABLE_DEPTH);
  localparam int unsigned DepthW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned ProdW  = AccW + DepthW;
  localparam int unsigned HiW    = ProdW - FracW;

  state_e             state_q, state_d;
  logic               active_q, active_d;
  logic [OctW-1:0]    k_q, k_d;
  logic               out_valid_q, out_valid_d;

  logic [AddrW-1:0]   coff_q, coff_d;
  logic [RadiusW-1:0] dx_q, dx_d;
  logic [RadiusW-1:0] dy_q, dy_d;
  logic [RadiusW-1:0] ndy_q, ndy_d;
  logic [AccW-1:0]    acc_q, acc_d;
  logic [RecipW-1:0]  recip_q, recip_d;
  logic [RadiusW-1:0] rad_q, rad_d;
  logic [ColorW-1:0]  col_q, col_d;
  logic [AddrW-1:0]   dxo_q, dxo_d;
  logic [AddrW-1:0]   dyo_q, dyo_d;
  logic [AddrW-1:0]   out_addr_q, out_addr_d;
  logic [ColorW-1:0]  out_col_q, out_col_d;
  logic               out_last_q, out_last_d;
  logic               out_done_q, out_done_d;

  div_req_t           div_req;
  div_rsp_t           div_rsp;
  logic [RootW-1:0]   root;
  logic [IdxW-1:0]    rom_idx;
  logic [ProdW-1:0]   idx_prod;
  logic [HiW-1:0]     idx_hi;
  logic [31:0]        coff_full;
  logic [31:0]        dxo_full;
  logic [31:0]        dyo_full;
  logic [RadiusW+RootW-1:0] scaled;
  logic [RadiusW-1:0] dx_inc;
  logic               finished;
  logic               in_fire;
  logic [AddrW-1:0]   sm_dx, sm_dy, pix;

  cotr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  cotr_rom #(
    .TableDepth (TABLE_DEPTH)
  ) u_rom (
    .clk_i  (clk_i),
    .addr_i (rom_idx),
    .data_o (root)
  );

  // Table index is floor(acc*depth/65536), clamped to the last entry.
  assign idx_prod = {{DepthW{1'b0}}, acc_q} * ProdW'(TABLE_DEPTH);
  assign idx_hi   = idx_prod[ProdW-1:FracW];
  assign rom_idx  = (idx_hi > HiW'(TABLE_DEPTH - 1)) ? IdxW'(TABLE_DEPTH - 1)
                                                      : idx_hi[IdxW-1:0];

  assign coff_full = 32'(in_i.center_y) * 32'(LINE_STRIDE) + 32'(in_i.center_x);
  assign dxo_full  = 32'(dx_q) * 32'(LINE_STRIDE);
  assign dyo_full  = 32'(dy_q) * 32'(LINE_STRIDE);
  assign scaled    = {{RootW{1'b0}}, rad_q} * {{RadiusW{1'b0}}, root};

  assign dx_inc     = dx_q + RadiusW'(1);
  assign finished   = dx_inc > ndy_q;
  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign sm_dx      = AddrW'(dx_q);
  assign sm_dy      = AddrW'(dy_q);

  // One octant address per cycle while the sink does not stall the output.
  always_comb begin
    case (k_q)
      3'd0:    pix = coff_q + sm_dy - dxo_q;
      3'd1:    pix = coff_q + sm_dx - dyo_q;
      3'd2:    pix = coff_q - sm_dx - dyo_q;
      3'd3:    pix = coff_q - sm_dy - dxo_q;
      3'd4:    pix = coff_q - sm_dy + dxo_q;
      3'd5:    pix = coff_q - sm_dx + dyo_q;
      3'd6:    pix = coff_q + sm_dx + dyo_q;
      default: pix = coff_q + sm_dy + dxo_q;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    active_d    = active_q;
    k_d         = k_q;
    out_valid_d = out_valid_q;
    coff_d      = coff_q;
    dx_d        = dx_q;
    dy_d        = dy_q;
    ndy_d       = ndy_q;
    acc_d       = acc_q;
    recip_d     = recip_q;
    rad_d       = rad_q;
    col_d       = col_q;
    dxo_d       = dxo_q;
    dyo_d       = dyo_q;
    out_addr_d  = out_addr_q;
    out_col_d   = out_col_q;
    out_last_d  = out_last_q;
    out_done_d  = out_done_q;
    div_req.start   = 1'b0;
    div_req.divisor = in_i.radius;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_i.opcode == OP_START) begin
            // A zero radius start is dropped without touching the state.
            if (in_i.radius != '0) begin
              coff_d        = coff_full[AddrW-1:0];
              rad_d         = in_i.radius;
              col_d         = in_i.color;
              dx_d          = '0;
              dy_d          = in_i.radius - RadiusW'(1);
              acc_d         = '0;
              active_d      = 1'b1;
              div_req.start = 1'b1;
              state_d       = ST_DIV;
            end
          end else if (active_q) begin
            acc_d   = acc_q + AccW'(recip_q);
            state_d = ST_FETCH;
          end
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          recip_d = div_rsp.quotient;
          state_d = ST_IDLE;
        end
      end
      ST_FETCH: begin
        dxo_d   = dxo_full[AddrW-1:0];
        dyo_d   = dyo_full[AddrW-1:0];
        state_d = ST_SCALE;
      end
      ST_SCALE: begin
        ndy_d   = scaled[FracW+RadiusW-1:FracW];
        k_d     = '0;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_addr_d  = pix;
          out_col_d   = col_q;
          out_last_d  = (k_q == LastOct);
          out_done_d  = (k_q == LastOct) && finished;
          k_d         = k_q + OctW'(1);
          if (k_q == LastOct) begin
            dx_d     = dx_inc;
            dy_d     = ndy_q;
            active_d = !finished;
            state_d  = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      active_q    <= 1'b0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      active_q    <= active_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    coff_q     <= coff_d;
    dx_q       <= dx_d;
    dy_q       <= dy_d;
    ndy_q      <= ndy_d;
    acc_q      <= acc_d;
    recip_q    <= recip_d;
    rad_q      <= rad_d;
    col_q      <= col_d;
    dxo_q      <= dxo_d;
    dyo_q      <= dyo_d;
    out_addr_q <= out_addr_d;
    out_col_q  <= out_col_d;
    out_last_q <= out_last_d;
    out_done_q <= out_done_d;
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.pixel_address = out_addr_q;
  assign out_o.pixel_color   = out_col_q;
  assign out_o.last          = out_last_q;
  assign out_o.done_res      = out_done_q;

  // A live circle never has its column past its row.
  a_active_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (dx_q <= dy_q))
    else $error("active circle with dx beyond dy");

  // The divider only answers while the sequencer waits for it.
  a_div_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == ST_DIV))
    else $error("divider result outside the divide state");

  // The finishing flag rides only on the eighth word of a step.
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_done_q) |-> out_last_q)
    else $error("done without last");

  // An accepted step of a live circle goes straight to the table read.
  a_step_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (in_i.opcode == OP_STEP) && active_q) |=> (state_q == ST_FETCH))
    else $error("step not followed by table read");

endmodule

`default_nettype wire

// ===== tb/sv/circle_outline_table_rasterizer_tb.sv =====
// Self-checking testbench for the table-driven circle outline rasterizer.
`timescale 1ns / 1ps

module circle_outline_table_rasterizer_tb;
  import cotr_pkg::*;

  localparam int unsigned HalfPeriod    = 10;
  localparam int unsigned Stride        = DefLineStride;
  localparam int unsigned Depth         = DefTableDepth;
  localparam int unsigned HoldCycles    = 400;
  localparam int unsigned SettleCycles  = 32;
  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned PhaseBudget   = 36;

  typedef struct packed {
    logic [AddrW-1:0]  addr;
    logic [ColorW-1:0] color;
    logic              last;
    logic              done;
  } pixel_t;

  logic clk_i   = 1'b0;
  logic rst_ni  = 1'b0;
  logic hold_rx = 1'b0;

  int src_idle_pct  = 15;
  int sink_idle_pct = 72;
  int stall_cycles  = 0;
  int mismatch_count   = 0;
  int pixels_checked   = 0;
  int words_sent       = 0;
  int circles_started  = 0;
  int circles_finished = 0;

  cotr_in_if  in_if ();
  cotr_out_if out_if ();

  circle_outline_table_rasterizer i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #HalfPeriod clk_i = ~clk_i;

  // Shadow copy of the rasterizer state.
  logic [RootW-1:0]   root_rom [Depth];
  logic               m_active = 1'b0;
  logic [AddrW-1:0]   m_center = '0;
  logic [RadiusW-1:0] m_dx     = '0;
  logic [RadiusW-1:0] m_dy     = '0;
  logic [AccW-1:0]    m_accum  = '0;
  logic [RecipW-1:0]  m_recip  = '0;
  logic [RadiusW-1:0] m_radius = '0;
  logic [ColorW-1:0]  m_color  = '0;

  pixel_t pending_pixels [$];

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int b = RootW - 1; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) begin
        r = t;
      end
    end
    return r;
  endfunction

  task automatic build_root_profile();
    longint unsigned d2;
    longint unsigned q;
    d2 = longint'(Depth) * longint'(Depth);
    for (int i = 0; i < Depth; i++) begin
      q = ((64'd1 << 32) * (d2 - longint'(i) * longint'(i))) / d2;
      root_rom[i] = RootW'(floor_sqrt(q));
    end
  endtask

  // Applies one accepted input word to the shadow state and queues the pixels it causes.
  task automatic rasterize_word(input op_e op, input logic [XW-1:0] x, input logic [YW-1:0] y,
                                input logic [RadiusW-1:0] r, input logic [ColorW-1:0] col);
    logic [AddrW-1:0] c;
    logic [AddrW-1:0] dxo;
    logic [AddrW-1:0] dyo;
    logic [AddrW-1:0] addr [8];
    int unsigned idx;
    int unsigned scaled;
    logic finished;
    pixel_t px;
    if (op == OP_START) begin
      if (r != 0) begin
        m_center = AddrW'(y * Stride + x);
        m_recip  = RecipW'(32'h1_0000 / r);
        m_dx     = '0;
        m_dy     = r - 7'd1;
        m_accum  = '0;
        m_radius = r;
        m_color  = col;
        m_active = 1'b1;
        circles_started++;
      end
    end else if (m_active) begin
      c   = m_center;
      dxo = AddrW'(m_dx * Stride);
      dyo = AddrW'(m_dy * Stride);
      addr[0] = c + m_dy - dxo;
      addr[1] = c + m_dx - dyo;
      addr[2] = c - m_dx - dyo;
      addr[3] = c - m_dy - dxo;
      addr[4] = c - m_dy + dxo;
      addr[5] = c - m_dx + dyo;
      addr[6] = c + m_dx + dyo;
      addr[7] = c + m_dy + dxo;

      m_dx    = m_dx + 7'd1;
      m_accum = m_accum + m_recip;
      idx     = (m_accum * Depth) >> FracW;
      // The accumulator can run past 1.0; the index then sticks at the last entry.
      if (idx > Depth - 1) begin
        idx = Depth - 1;
      end
      scaled   = 32'(m_radius) * 32'(root_rom[idx]);
      m_dy     = RadiusW'(scaled >> FracW);
      finished = m_dx > m_dy;

      for (int k = 0; k < 8; k++) begin
        px.addr  = addr[k];
        px.color = m_color;
        px.last  = (k == LastOct);
        px.done  = (k == LastOct) && finished;
        pending_pixels.push_back(px);
      end
      if (finished) begin
        m_active = 1'b0;
        circles_finished++;
      end
    end
  endtask

  // Offers one word; valid stays high afterwards so back-to-back words need no gap.
  task automatic send_word(input op_e op, input logic [XW-1:0] x, input logic [YW-1:0] y,
                           input logic [RadiusW-1:0] r, input logic [ColorW-1:0] col);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid    <= 1'b1;
    in_if.opcode   <= op;
    in_if.center_x <= x;
    in_if.center_y <= y;
    in_if.radius   <= r;
    in_if.color    <= col;
    do @(posedge clk_i); while (!in_if.ready);
    words_sent++;
    rasterize_word(op, x, y, r, col);
  endtask

  // Steps the current circle until it finishes or max_steps words have gone out.
  // Step words carry random payload, which the block must ignore.
  task automatic step_circle(input int max_steps, output int taken);
    taken = 0;
    while (m_active && taken < max_steps) begin
      send_word(OP_STEP, XW'($urandom_range(511)), YW'($urandom_range(255)),
                RadiusW'($urandom_range(127)), ColorW'($urandom_range(255)));
      taken++;
    end
  endtask

  task automatic drain_pixels();
    in_if.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic test_idle_and_zero_radius();
    send_word(OP_STEP, '0, '0, '0, '0);
    send_word(OP_START, 9'h1FF, 8'hFF, 7'd0, 8'hFF);
    send_word(OP_STEP, 9'h1FF, 8'hFF, 7'h7F, 8'hFF);
  endtask

  task automatic test_extremes_and_clamp();
    int taken;
    // Radius one finishes on its first step, which drives the table index past the end.
    send_word(OP_START, '0, '0, 7'd1, '0);
    step_circle(1, taken);
    send_word(OP_STEP, '0, '0, '0, '0);
    send_word(OP_START, 9'd319, 8'd199, 7'd127, 8'd255);
    step_circle(3, taken);
  endtask

  task automatic test_restart_and_wrap();
    int taken;
    // This start drops the large circle still in progress; its centre lies off screen.
    send_word(OP_START, 9'h1FF, 8'hFF, 7'd2, 8'hA5);
    step_circle(8, taken);
    send_word(OP_STEP, 9'd5, 8'd5, 7'd5, 8'd5);
    send_word(OP_START, 9'd160, 8'd100, 7'd5, 8'h5A);
    step_circle(16, taken);
  endtask

  task automatic test_sink_holdoff();
    int taken;
    hold_rx <= 1'b1;
    fork
      begin
        repeat (HoldCycles) @(posedge clk_i);
        hold_rx <= 1'b0;
      end
    join_none
    send_word(OP_START, XW'($urandom_range(319)), YW'($urandom_range(199)), 7'd100,
              ColorW'($urandom_range(255)));
    step_circle(24, taken);
    drain_pixels();
  endtask

  task automatic test_random_traffic(input int budget);
    int pick;
    int taken;
    int cap;
    logic [RadiusW-1:0] r;
    while (budget > 0) begin
      pick = $urandom_range(99);
      if (pick < 6) begin
        send_word(OP_START, XW'($urandom_range(511)), YW'($urandom_range(255)), 7'd0,
                  ColorW'($urandom_range(255)));
      end else if (pick < 12 && !m_active) begin
        send_word(OP_STEP, XW'($urandom_range(511)), YW'($urandom_range(255)),
                  RadiusW'($urandom_range(127)), ColorW'($urandom_range(255)));
      end else begin
        pick = $urandom_range(99);
        if (pick < 80) begin
          r = RadiusW'($urandom_range(15, 1));
        end else if (pick < 95) begin
          r = RadiusW'($urandom_range(60, 16));
        end else begin
          r = RadiusW'($urandom_range(127, 61));
        end
        send_word(OP_START,
                  XW'(($urandom_range(7) == 0) ? $urandom_range(511) : $urandom_range(319)),
                  YW'(($urandom_range(7) == 0) ? $urandom_range(255) : $urandom_range(199)),
                  r, ColorW'($urandom_range(255)));
        budget--;
        // Now and then a circle is abandoned early so the next start replaces it.
        cap = ($urandom_range(9) == 0) ? $urandom_range(6, 1) : budget;
        step_circle(cap, taken);
        budget -= taken;
      end
    end
  endtask

  // Sink side: checks every accepted pixel word against the oldest expectation.
  always @(posedge clk_i) begin
    pixel_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_pixels.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected pixel word: addr=%h color=%h last=%b done=%b", $time,
                 out_if.pixel_address, out_if.pixel_color, out_if.last, out_if.done_res);
      end else begin
        want = pending_pixels.pop_front();
        pixels_checked++;
        if (out_if.pixel_address !== want.addr || out_if.pixel_color !== want.color ||
            out_if.last !== want.last || out_if.done_res !== want.done) begin
          mismatch_count++;
          $display("%0t: pixel mismatch: expected addr=%h color=%h last=%b done=%b,",
                   $time, want.addr, want.color, want.last, want.done);
          $display("%0t:                 got      addr=%h color=%h last=%b done=%b",
                   $time, out_if.pixel_address, out_if.pixel_color, out_if.last,
                   out_if.done_res);
        end
      end
    end
    out_if.ready <= hold_rx ? 1'b0 : ($urandom_range(99) >= sink_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles + 1 >= WatchdogLimit) begin
        $display("%0t: no word accepted for %0d cycles", $time, WatchdogLimit);
        $display("circle_outline_table_rasterizer_tb: FAIL");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    in_if.valid    = 1'b0;
    in_if.opcode   = OP_START;
    in_if.center_x = '0;
    in_if.center_y = '0;
    in_if.radius   = '0;
    in_if.color    = '0;
    out_if.ready   = 1'b0;
    build_root_profile();

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    src_idle_pct  = 15;
    sink_idle_pct = 72;
    test_idle_and_zero_radius();
    test_extremes_and_clamp();
    test_restart_and_wrap();
    test_sink_holdoff();
    test_random_traffic(PhaseBudget);
    drain_pixels();

    src_idle_pct  = 72;
    sink_idle_pct = 15;
    test_random_traffic(PhaseBudget);
    drain_pixels();

    src_idle_pct  = 0;
    sink_idle_pct = 0;
    test_random_traffic(PhaseBudget);
    drain_pixels();

    $display("Sent %0d words: %0d circles started, %0d finished, %0d pixel words checked.",
             words_sent, circles_started, circles_finished, pixels_checked);
    $display("Ran sender-heavy, sink-heavy and gap-free idling plus a %0d-cycle sink hold-off.",
             HoldCycles);
    if (mismatch_count == 0) begin
      $display("circle_outline_table_rasterizer_tb: PASS");
    end else begin
      $display("circle_outline_table_rasterizer_tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/cotr_pkg.sv
hdl/cotr_if.sv
hdl/cotr_div.sv
hdl/cotr_rom.sv
hdl/circle_outline_table_rasterizer.sv
tb/sv/circle_outline_table_rasterizer_tb.sv
